[src/hiseq_pkg.sv]
// Shared constants and sequencer state type for the histogram equalizer.
`default_nettype none

package hiseq_pkg;

  // Grey level width of the pixel stream.
  localparam int PIX_W = 8;

  // Default geometry.
  localparam int IMAGE_SIDE_DEF = 256;
  localparam int LEVELS_DEF     = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATH_WR,
    ST_MAP_OUT,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_MUL,
    ST_BLD_DIV
  } seq_state_t;

endpackage

`default_nettype wire

[src/histogram_equalizer_core.sv]
// Top level of the two-pass histogram equalizer: sequencer, histogram and table.
// Gather pixel: accept, then bin read-modify-write; input stalls meanwhile.
// Map pixel: accept, then the result is loaded once the output register is free; input
//   stalls until it is loaded; a pending result does not block the next accept.
// Table build after the last gather pixel (skipped when no pixel was counted):
//   the bit-serial divider runs once per grey level.
// Reset (rst, synchronous): histogram, pixel total and table-valid flag clear
//   at once through per-bin valid flags; no clearing pass. Table RAM is not reset.
`default_nettype none

module histogram_equalizer_core #(
  parameter int IMAGE_SIDE = hiseq_pkg::IMAGE_SIDE_DEF,
  parameter int LEVELS     = hiseq_pkg::LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Pixel request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [hiseq_pkg::PIX_W-1:0] pixel,
  input  wire logic                        last,
  // Mapped pixel channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [hiseq_pkg::PIX_W-1:0] mapped_pixel,
  output logic                             last_out
);

  import hiseq_pkg::*;

  // Geometry derived from the parameters.
  localparam int TOP   = LEVELS - 1;
  localparam int LIMIT = IMAGE_SIDE * IMAGE_SIDE;
  localparam int LW    = $clog2(LEVELS);
  localparam int CW    = $clog2(LIMIT + 1);          // bin count and total width
  localparam int KW    = $clog2(2 * TOP + 1);        // width of the 2*TOP factor
  localparam int NW    = $clog2(LIMIT * (2 * TOP + 1) + 1);
  localparam int DENW  = CW + 1;                     // 2 * total
  localparam int QW    = LW;                         // quotient stays below LEVELS
  localparam int DVW   = (NW > DENW + QW - 1) ? NW : DENW + QW - 1;
  localparam int PW    = CW + KW;

  // Sequencer and datapath registers.
  seq_state_t        state, state_next;
  logic [LW-1:0]     g_reg, g_reg_next;
  logic              last_reg, last_reg_next;
  logic [LEVELS-1:0] bin_vld, bin_vld_next;
  logic [CW-1:0]     total, total_next;
  logic              map_valid, map_valid_next;
  logic [CW-1:0]     cum, cum_next;
  logic [LW-1:0]     g_cnt, g_cnt_next;
  logic              out_valid_next;
  logic [PIX_W-1:0]  mapped_pixel_next;
  logic              last_out_next;

  // Combinational signals.
  logic              accept;
  logic [PIX_W-1:0]  pix_clamp;
  logic [LW-1:0]     g_in;
  logic              bin_rd_en;
  logic [LW-1:0]     bin_rd_addr;
  logic [CW-1:0]     bin_rd_data;
  logic              bin_wr_en;
  logic [CW-1:0]     bin_wr_data;
  logic [LW-1:0]     bin_idx;
  logic [CW-1:0]     bin_val;
  logic              count_ok;
  logic [CW:0]       cum_sum;
  logic [PW-1:0]     prod;
  logic [DVW-1:0]    div_num;
  logic [DENW-1:0]   div_den;
  logic              div_start;
  logic [QW-1:0]     div_quot;
  logic              div_done;
  logic [QW-1:0]     quot_clamp;
  logic              map_rd_en;
  logic [PIX_W-1:0]  map_rd_data;
  logic              map_wr_en;
  logic [PIX_W-1:0]  map_wr_data;

  // Grey levels at or above LEVELS fold onto the top level.
  assign pix_clamp = (pixel > PIX_W'(TOP)) ? PIX_W'(TOP) : pixel;
  assign g_in      = LW'(pix_clamp);

  // Input is taken only while the sequencer rests.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Bin RAM read: the incoming pixel on a gather accept, the sweep index on build.
  assign bin_rd_en   = (accept && !action) || (state == ST_BLD_RD);
  assign bin_rd_addr = (state == ST_BLD_RD) ? g_cnt : g_in;

  // A bin whose valid flag is down reads as zero.
  assign bin_idx = (state == ST_BLD_ACC) ? g_cnt : g_reg;
  assign bin_val = bin_vld[bin_idx] ? bin_rd_data : '0;

  // Stop counting once the image is full.
  assign count_ok    = (total < CW'(LIMIT));
  assign bin_wr_data = bin_val + CW'(1);

  // Running cumulative count, held at the total.
  assign cum_sum = {1'b0, cum} + {1'b0, bin_val};

  // Rounded quotient numerator: 2*TOP*cum + total, over 2*total.
  assign prod    = PW'(cum) * PW'(2 * TOP);
  assign div_num = DVW'(prod) + DVW'(total);
  assign div_den = {total, 1'b0};

  assign quot_clamp  = (div_quot > QW'(TOP)) ? QW'(TOP) : div_quot;
  assign map_wr_data = PIX_W'(quot_clamp);

  // Map RAM read is issued on the map accept itself.
  assign map_rd_en = accept && action;

  always_comb begin
    state_next        = state;
    g_reg_next        = g_reg;
    last_reg_next     = last_reg;
    bin_vld_next      = bin_vld;
    total_next        = total;
    map_valid_next    = map_valid;
    cum_next          = cum;
    g_cnt_next        = g_cnt;
    out_valid_next    = out_valid && out_stall;
    mapped_pixel_next = mapped_pixel;
    last_out_next     = last_out;
    bin_wr_en         = 1'b0;
    map_wr_en         = 1'b0;
    div_start         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          g_reg_next    = g_in;
          last_reg_next = last;
          state_next    = action ? ST_MAP_OUT : ST_GATH_WR;
        end
      end

      ST_GATH_WR: begin
        // Finish the read-modify-write of the bin, then build on the last pixel.
        if (count_ok) begin
          bin_wr_en           = 1'b1;
          bin_vld_next[g_reg] = 1'b1;
          total_next          = total + CW'(1);
        end
        state_next = ST_IDLE;
        if (last_reg) begin
          if (total_next == '0) begin
            map_valid_next = 1'b0;
          end else begin
            g_cnt_next = '0;
            cum_next   = '0;
            state_next = ST_BLD_RD;
          end
        end
      end

      ST_MAP_OUT: begin
        // Hold until the output register is free or is drained this cycle.
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          mapped_pixel_next = map_valid ? map_rd_data : PIX_W'(g_reg);
          last_out_next     = last_reg;
          state_next        = ST_IDLE;
          if (last_reg) begin
            bin_vld_next   = '0;
            total_next     = '0;
            map_valid_next = 1'b0;
          end
        end
      end

      ST_BLD_RD: begin
        state_next = ST_BLD_ACC;
      end

      ST_BLD_ACC: begin
        cum_next   = (cum_sum > {1'b0, total}) ? total : CW'(cum_sum);
        state_next = ST_BLD_MUL;
      end

      ST_BLD_MUL: begin
        // Numerator is registered inside the divider on start.
        div_start  = 1'b1;
        state_next = ST_BLD_DIV;
      end

      ST_BLD_DIV: begin
        if (div_done) begin
          map_wr_en = 1'b1;
          if (g_cnt == LW'(TOP)) begin
            map_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            g_cnt_next = g_cnt + LW'(1);
            state_next = ST_BLD_RD;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bin_vld   <= '0;
      total     <= '0;
      map_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bin_vld   <= bin_vld_next;
      total     <= total_next;
      map_valid <= map_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and sweep registers.
  always_ff @(posedge clk) begin
    g_reg        <= g_reg_next;
    last_reg     <= last_reg_next;
    cum          <= cum_next;
    g_cnt        <= g_cnt_next;
    mapped_pixel <= mapped_pixel_next;
    last_out     <= last_out_next;
  end

  // Histogram bins.
  hiseq_ram #(
    .WIDTH (CW),
    .DEPTH (LEVELS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_wr_en),
    .wr_addr (g_reg),
    .wr_data (bin_wr_data),
    .rd_en   (bin_rd_en),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd_data)
  );

  // Mapping table.
  hiseq_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LEVELS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (g_cnt),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (g_in),
    .rd_data (map_rd_data)
  );

  // Shared divider for the rounded table entries.
  hiseq_div #(
    .WIDE (DVW),
    .DENW (DENW),
    .QW   (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

endmodule

`default_nettype wire

[src/hiseq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hiseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/hiseq_div.sv]
// Restoring divider, one quotient bit per cycle, for the mapping table build.
`default_nettype none

module hiseq_div #(
  parameter int WIDE = 25,
  parameter int DENW = 18,
  parameter int QW   = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [WIDE-1:0] num,
  input  wire logic [DENW-1:0] den,
  output logic      [QW-1:0]   quot,
  output logic                 done
);

  localparam int CNTW = $clog2(QW + 1);

  logic [WIDE-1:0] rem;
  logic [WIDE-1:0] dsh;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            ge;

  // Quotient is known to fit in QW bits, so start with the divisor at bit QW-1.
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNTW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= WIDE'(den) << (QW - 1);
      quot <= '0;
      cnt  <= CNTW'(QW);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= (quot << 1) | QW'(ge);
      dsh  <= dsh >> 1;
      cnt  <= cnt - CNTW'(1);
    end
  end

endmodule

`default_nettype wire
